// ===== sv/bwl_pkg.sv =====
// ----------------------------------------------------------------------------
// bwl_pkg: shared types for the bounded-wait lock hand-off block
// Transaction payloads, result status codes and the cell control bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bwl_pkg;

  localparam int ThreadW = 4;
  localparam int StatusW = 3;
  localparam int CountW  = 5;

  // result status codes
  localparam logic [StatusW-1:0] ST_GRANTED = 3'd0;
  localparam logic [StatusW-1:0] ST_QUEUED  = 3'd1;
  localparam logic [StatusW-1:0] ST_HANDOFF = 3'd2;
  localparam logic [StatusW-1:0] ST_FREED   = 3'd3;
  localparam logic [StatusW-1:0] ST_IGNORED = 3'd4;

  // operation codes
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic               op;
    logic [ThreadW-1:0] thread_id;
  } in_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ThreadW-1:0] granted_thread;
    logic               lock_busy_out;
  } out_t;

  // broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic               set;     // mark thread id as waiting
    logic               take;    // clear the flag under the token (hand-off)
    logic               load;    // place the token at the start position
    logic               shift;   // move the token one cell along the ring
    logic               shrink;  // clear flags at or above the count
    logic [ThreadW-1:0] id;
  } cell_ctl_t;

  // per-cell status back to the sequencer and neighbors
  typedef struct packed {
    logic hit;      // token sits on a waiting thread
    logic id_wait;  // this cell is the addressed thread and it waits
    logic pass;     // token moves to the next cell
    logic wrap;     // token wraps to cell 0
  } cell_stat_t;

endpackage

// ===== sv/bwl_cell.sv =====
// ----------------------------------------------------------------------------
// bwl_cell: one thread slot of the round-robin ring
// Holds the waiting flag of one thread and the scan token bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bwl_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 5,
  parameter int IW    = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  bwl_pkg::cell_ctl_t  ctl,
  input  logic [IW-1:0]       pos,
  input  logic [CW-1:0]       count,
  input  logic                token_in,
  output bwl_pkg::cell_stat_t stat
);

  logic flag;
  logic token;
  logic is_me;
  logic at_pos;
  logic last;
  logic above;

  assign is_me  = (32'(ctl.id) == INDEX);
  assign at_pos = (pos == IW'(INDEX));
  assign last   = (CW'(INDEX) == (count - CW'(1)));
  assign above  = (CW'(INDEX) >= count);

  // waiting flag and token
  always_ff @(posedge clk) begin
    if (rst) begin
      flag  <= 1'b0;
      token <= 1'b0;
    end else begin
      if (ctl.shrink && above) begin
        flag <= 1'b0;
      end else if (ctl.take && token) begin
        flag <= 1'b0;
      end else if (ctl.set && is_me) begin
        flag <= 1'b1;
      end

      if (ctl.load) begin
        token <= at_pos;
      end else if (ctl.shift) begin
        token <= token_in;
      end
    end
  end

  assign stat.hit     = token & flag;
  assign stat.id_wait = is_me & flag;
  assign stat.pass    = token & ~last;
  assign stat.wrap    = token & last;

endmodule

// ===== sv/bounded_wait_lock_handoff_top.sv =====
// ----------------------------------------------------------------------------
// bounded_wait_lock_handoff_top: lock manager with round-robin hand-off
// One lock, a ring of thread cells and a scan sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid / in_stall / in_data): one request or release per
//     transaction. out channel (out_valid / out_stall / out_data): exactly one
//     result per input transaction, in order.
//   cfg_we / cfg_wdata write num_threads; write only while the block is idle.
//   Results: a request, an ignored item, or a release with no other thread in
//     use gives its result in the cycle after acceptance. A release by the holder
//     walks a token round the ring one cell per cycle, starting after the
//     holder, until the first waiting cell or the end of the walk; the result
//     is registered there once the output slot is free.
//   Throughput: one item per cycle for requests while the output is not stalled;
//     a release scan blocks new items until it finishes.
//   Reset (synchronous rst): lock free, holder 0, no thread waiting,
//     num_threads 16, output empty.
//   A stalled result holds in the output register; a new item is still taken
//     if the slot frees in the same cycle, otherwise in_stall is raised.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_wait_lock_handoff_top #(
  parameter int MAX_THREADS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  bwl_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output bwl_pkg::out_t                out_data,
  input  logic                         cfg_we,
  input  logic [bwl_pkg::CountW-1:0]   cfg_wdata
);

  localparam int CW = $clog2(MAX_THREADS + 1);
  localparam int IW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;

  localparam logic IDLE = 1'b0;
  localparam logic SCAN = 1'b1;

  // registers
  logic                           state, state_next;
  logic                           busy, busy_next;
  logic [bwl_pkg::ThreadW-1:0]    holder, holder_next;
  logic [bwl_pkg::CountW-1:0]     num_threads;
  logic [IW-1:0]                  pos, pos_next;
  logic [CW-1:0]                  steps, steps_next;

  logic [CW-1:0]                  eff_cur;
  logic [CW-1:0]                  eff_new;
  logic [CW-1:0]                  cell_count;
  logic                           acc;
  logic                           out_free;
  logic                           id_ok;
  logic                           is_holder;
  logic                           id_wait;
  logic                           hit;
  logic                           wrap_any;
  logic                           emit;
  logic [bwl_pkg::StatusW-1:0]    status;
  logic [IW-1:0]                  start_pos;
  logic [IW-1:0]                  pos_inc;
  bwl_pkg::cell_ctl_t             ctl;
  bwl_pkg::cell_stat_t            stat [MAX_THREADS];
  logic [MAX_THREADS-1:0]         hit_vec, wait_vec, wrap_vec;

  // effective thread count: 0 acts as 1, clamp at MAX_THREADS
  function automatic logic [CW-1:0] eff_count(input logic [bwl_pkg::CountW-1:0] v);
    logic [CW-1:0] r;
    if (v == '0) begin
      r = CW'(1);
    end else if (32'(v) > MAX_THREADS) begin
      r = CW'(MAX_THREADS);
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  assign eff_cur    = eff_count(num_threads);
  assign eff_new    = eff_count(cfg_wdata);
  assign cell_count = cfg_we ? eff_new : eff_cur;

  // handshakes
  assign out_free = ~out_valid | ~out_stall;
  assign in_stall = (state != IDLE) | ~out_free;
  assign acc      = in_valid & ~in_stall;

  // cell ring
  genvar gi;
  generate
    for (gi = 0; gi < MAX_THREADS; gi++) begin : g_cell
      logic tok_in;
      if (gi == 0) begin : g_first
        assign tok_in = wrap_any;
      end else begin : g_rest
        assign tok_in = stat[gi-1].pass;
      end

      bwl_cell #(
        .INDEX (gi),
        .CW    (CW),
        .IW    (IW)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .pos      (pos_next),
        .count    (cell_count),
        .token_in (tok_in),
        .stat     (stat[gi])
      );

      assign hit_vec[gi]  = stat[gi].hit;
      assign wait_vec[gi] = stat[gi].id_wait;
      assign wrap_vec[gi] = stat[gi].wrap;
    end
  endgenerate

  assign hit      = |hit_vec;
  assign id_wait  = |wait_vec;
  assign wrap_any = |wrap_vec;

  assign id_ok     = (32'(in_data.thread_id) < 32'(eff_cur));
  assign is_holder = busy && (holder == in_data.thread_id);
  assign start_pos = ((32'(in_data.thread_id) + 1) == 32'(eff_cur)) ? '0
                   : IW'(32'(in_data.thread_id) + 1);
  assign pos_inc   = ((32'(pos) + 1) == 32'(eff_cur)) ? '0 : IW'(32'(pos) + 1);

  // sequencer
  always_comb begin
    state_next  = state;
    busy_next   = busy;
    holder_next = holder;
    pos_next    = pos;
    steps_next  = steps;
    emit        = 1'b0;
    status      = bwl_pkg::ST_IGNORED;
    ctl         = '0;
    ctl.id      = in_data.thread_id;
    ctl.shrink  = cfg_we;

    unique case (state)
      IDLE: begin
        if (acc) begin
          emit = 1'b1;
          if (!id_ok) begin
            status = bwl_pkg::ST_IGNORED;
          end else if (in_data.op == bwl_pkg::OP_REQUEST) begin
            if (is_holder || id_wait) begin
              status = bwl_pkg::ST_IGNORED;
            end else if (!busy) begin
              status      = bwl_pkg::ST_GRANTED;
              busy_next   = 1'b1;
              holder_next = in_data.thread_id;
            end else begin
              status  = bwl_pkg::ST_QUEUED;
              ctl.set = 1'b1;
            end
          end else if (is_holder) begin
            if (eff_cur == CW'(1)) begin
              status      = bwl_pkg::ST_FREED;
              busy_next   = 1'b0;
              holder_next = '0;
            end else begin
              // start the round-robin walk after the holder
              emit       = 1'b0;
              ctl.load   = 1'b1;
              pos_next   = start_pos;
              steps_next = eff_cur - CW'(1);
              state_next = SCAN;
            end
          end else begin
            status = bwl_pkg::ST_IGNORED;
          end
        end
      end
      SCAN: begin
        if (hit) begin
          if (out_free) begin
            emit        = 1'b1;
            status      = bwl_pkg::ST_HANDOFF;
            ctl.take    = 1'b1;
            holder_next = bwl_pkg::ThreadW'(pos);
            state_next  = IDLE;
          end
        end else if (steps == CW'(1)) begin
          if (out_free) begin
            emit        = 1'b1;
            status      = bwl_pkg::ST_FREED;
            busy_next   = 1'b0;
            holder_next = '0;
            state_next  = IDLE;
          end
        end else begin
          ctl.shift  = 1'b1;
          pos_next   = pos_inc;
          steps_next = steps - CW'(1);
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      busy        <= 1'b0;
      holder      <= '0;
      num_threads <= bwl_pkg::CountW'(16);
      pos         <= '0;
      steps       <= '0;
      out_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      busy      <= busy_next;
      holder    <= holder_next;
      pos       <= pos_next;
      steps     <= steps_next;
      out_valid <= emit | (out_valid & out_stall);
      if (cfg_we) begin
        num_threads <= cfg_wdata;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.status         <= status;
      out_data.granted_thread <= busy_next ? holder_next : '0;
      out_data.lock_busy_out  <= busy_next;
    end
  end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: regression for bounded_wait_lock_handoff_top
// Drives lock requests and releases through bursty valid/stall traffic. A
// shadow copy of the lock, holder and wait flags predicts every result. The
// thread count changes between phases. Results are checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int NumSlots     = 16;
  localparam int ResetCount   = 16;
  localparam int DrainCycles  = 24;      // longest release scan plus margin
  localparam int CycleLimit   = 300000;
  localparam int PhaseItems   = 35;

  // receiver stall modes
  localparam logic [1:0] STALL_NONE  = 2'd0;
  localparam logic [1:0] STALL_LIGHT = 2'd1;
  localparam logic [1:0] STALL_HEAVY = 2'd2;
  localparam logic [1:0] STALL_TOGGLE = 2'd3;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  bwl_pkg::in_t                in_data = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  bwl_pkg::out_t               out_data;
  logic                        cfg_we = 1'b0;
  logic [bwl_pkg::CountW-1:0]  cfg_wdata = '0;

  logic [1:0]          stall_mode = STALL_NONE;
  logic [5:0]          stall_phase = '0;
  int                  cycle_count = 0;
  int                  burst_left = 0;

  // Shadow of the lock manager plus the in-order list of expected results
  class lock_shadow;
    logic [bwl_pkg::CountW-1:0]  count_reg;
    bit                          busy;
    logic [bwl_pkg::ThreadW-1:0] owner;
    bit [NumSlots-1:0]           waiting;
    bwl_pkg::out_t               expected_results[$];
    int                          errors;

    function new();
      count_reg = bwl_pkg::CountW'(ResetCount);
      busy      = 1'b0;
      owner     = '0;
      waiting   = '0;
      errors    = 0;
    endfunction

    function int unsigned eff_count();
      if (count_reg == 0) return 1;
      if (count_reg > NumSlots) return NumSlots;
      return count_reg;
    endfunction

    // count write: drop waiters that fall outside the new range
    function void apply_count(logic [bwl_pkg::CountW-1:0] value);
      int unsigned n;
      count_reg = value;
      n = eff_count();
      for (int unsigned t = n; t < NumSlots; t++) waiting[t] = 1'b0;
    endfunction

    function void note_item(bwl_pkg::in_t item);
      int unsigned                 n;
      int unsigned                 j;
      int unsigned                 k;
      bit                          found;
      logic [bwl_pkg::StatusW-1:0] st;
      bwl_pkg::out_t               res;
      n  = eff_count();
      st = bwl_pkg::ST_IGNORED;
      if (item.thread_id < n) begin
        if (item.op == bwl_pkg::OP_REQUEST) begin
          if ((busy && owner == item.thread_id) || waiting[item.thread_id]) begin
            st = bwl_pkg::ST_IGNORED;
          end else if (!busy) begin
            busy  = 1'b1;
            owner = item.thread_id;
            st    = bwl_pkg::ST_GRANTED;
          end else begin
            waiting[item.thread_id] = 1'b1;
            st = bwl_pkg::ST_QUEUED;
          end
        end else if (busy && owner == item.thread_id) begin
          // round-robin search starting after the holder
          found = 1'b0;
          j     = item.thread_id;
          for (k = 1; k < n && !found; k++) begin
            j = (j + 1) % n;
            if (waiting[j]) found = 1'b1;
          end
          if (found) begin
            waiting[j] = 1'b0;
            owner      = bwl_pkg::ThreadW'(j);
            st         = bwl_pkg::ST_HANDOFF;
          end else begin
            busy  = 1'b0;
            owner = '0;
            st    = bwl_pkg::ST_FREED;
          end
        end
      end
      res.status         = st;
      res.granted_thread = busy ? owner : '0;
      res.lock_busy_out  = busy;
      expected_results.push_back(res);
    endfunction

    function void check_result(bwl_pkg::out_t got);
      bwl_pkg::out_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: status %0d thread %0d busy %0d",
               got.status, got.granted_thread, got.lock_busy_out);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.granted_thread !== want.granted_thread) begin
        $error("granted_thread: expected %0d, actual %0d",
               want.granted_thread, got.granted_thread);
        errors++;
      end
      if (got.lock_busy_out !== want.lock_busy_out) begin
        $error("lock_busy_out: expected %0d, actual %0d",
               want.lock_busy_out, got.lock_busy_out);
        errors++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  lock_shadow shadow = new();

  bounded_wait_lock_handoff_top #(
    .MAX_THREADS (NumSlots)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // monitor: sample handshakes and config writes at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) shadow.apply_count(cfg_wdata);
      if (in_valid && !in_stall) shadow.note_item(in_data);
      if (out_valid && !out_stall) shadow.check_result(out_data);
    end
  end

  // receiver backpressure: mode picked each time the 6-bit phase counter wraps
  always @(posedge clk) begin
    if (rst) begin
      out_stall   <= 1'b0;
      stall_phase <= '0;
    end else begin
      stall_phase <= stall_phase + 6'd1;
      if (stall_phase == '0) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:  out_stall <= ($urandom_range(0, 9) < 6);
        STALL_TOGGLE: out_stall <= stall_phase[1];
        default:      out_stall <= 1'b0;
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("bounded_wait_lock_handoff_top regression: fail");
      $finish;
    end
  end

  function automatic bwl_pkg::in_t mk(logic op, int unsigned id);
    bwl_pkg::in_t item;
    item.op        = op;
    item.thread_id = bwl_pkg::ThreadW'(id);
    return item;
  endfunction

  // bursts of random length separated by random gaps
  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 10);
    return $urandom_range(1, 6);
  endfunction

  // hold the transaction until accepted, then optionally go quiet
  task automatic send_item(input bwl_pkg::in_t item);
    int gap;
    gap = next_gap();
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  task automatic set_count(input logic [bwl_pkg::CountW-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly well-formed traffic biased by the current lock state
  function automatic bwl_pkg::in_t pick_item();
    bwl_pkg::in_t item;
    int unsigned  n;
    int unsigned  roll;
    n    = shadow.eff_count();
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      item = mk(1'($urandom_range(0, 1)), $urandom_range(0, NumSlots - 1));
    end else if (roll < 50 && shadow.busy) begin
      item = mk(bwl_pkg::OP_RELEASE, int'(shadow.owner));
    end else begin
      item = mk(bwl_pkg::OP_REQUEST, $urandom_range(0, n - 1));
    end
    return item;
  endfunction

  initial begin
    logic [bwl_pkg::CountW-1:0] phase_counts[$];
    phase_counts = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd0, 5'd2, 5'd9, 5'd16, 5'd3, 5'd12, 5'd17};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: grant, duplicates, queueing, hand-off order and wrap, freeing
    send_item(mk(bwl_pkg::OP_REQUEST, 0));
    send_item(mk(bwl_pkg::OP_REQUEST, 0));
    send_item(mk(bwl_pkg::OP_REQUEST, 15));
    send_item(mk(bwl_pkg::OP_REQUEST, 15));
    send_item(mk(bwl_pkg::OP_REQUEST, 5));
    send_item(mk(bwl_pkg::OP_RELEASE, 5));
    send_item(mk(bwl_pkg::OP_RELEASE, 0));
    send_item(mk(bwl_pkg::OP_RELEASE, 5));
    send_item(mk(bwl_pkg::OP_RELEASE, 15));
    send_item(mk(bwl_pkg::OP_RELEASE, 15));
    send_item(mk(bwl_pkg::OP_REQUEST, 15));
    send_item(mk(bwl_pkg::OP_REQUEST, 3));
    send_item(mk(bwl_pkg::OP_RELEASE, 15));
    send_item(mk(bwl_pkg::OP_RELEASE, 3));
    send_item(mk(bwl_pkg::OP_REQUEST, 10));
    send_item(mk(bwl_pkg::OP_REQUEST, 12));
    send_item(mk(bwl_pkg::OP_REQUEST, 2));

    // shrink below the holder: waiter above the count dropped, holder stuck
    set_count(5'd8);
    send_item(mk(bwl_pkg::OP_RELEASE, 10));
    send_item(mk(bwl_pkg::OP_REQUEST, 12));
    send_item(mk(bwl_pkg::OP_REQUEST, 2));

    // zero count acts as one thread
    set_count(5'd0);
    send_item(mk(bwl_pkg::OP_REQUEST, 1));
    send_item(mk(bwl_pkg::OP_REQUEST, 0));

    // count above the maximum clamps; stuck holder can release again
    set_count(5'd31);
    send_item(mk(bwl_pkg::OP_RELEASE, 10));
    send_item(mk(bwl_pkg::OP_RELEASE, 0));
    send_item(mk(bwl_pkg::OP_RELEASE, 2));

    // random phases over a range of thread counts
    foreach (phase_counts[p]) begin
      set_count(phase_counts[p]);
      repeat (PhaseItems) send_item(pick_item());
    end
    set_count(5'($urandom_range(1, 31)));
    repeat (PhaseItems) send_item(pick_item());

    drain();
    repeat (DrainCycles) @(posedge clk);

    if (shadow.pending() != 0) begin
      $error("%0d expected results never arrived", shadow.pending());
      shadow.errors++;
    end
    if (shadow.errors == 0) begin
      $display("bounded_wait_lock_handoff_top regression: pass");
    end else begin
      $display("bounded_wait_lock_handoff_top regression: fail");
    end
    $finish;
  end

endmodule
